@@ sv/i2cbm_pkg.sv @@
package i2cbm_pkg;

  localparam logic [15:0] PHASE_TICKS_RESET = 16'd2;
  localparam logic [7:0]  ACK_TIMEOUT_RESET = 8'd250;
  localparam int          QUEUE_DEPTH_DEFAULT = 2;

  localparam logic [2:0] REQ_TICK  = 3'd0;
  localparam logic [2:0] REQ_START = 3'd1;
  localparam logic [2:0] REQ_STOP  = 3'd2;
  localparam logic [2:0] REQ_WRITE = 3'd3;
  localparam logic [2:0] REQ_READ  = 3'd4;
  localparam logic [2:0] REQ_ACK   = 3'd5;

  localparam logic [0:0] REG_PHASE_TICKS = 1'd0;
  localparam logic [0:0] REG_ACK_TIMEOUT = 1'd1;

  typedef enum logic [2:0] {
    CMD_TICK,
    CMD_START,
    CMD_STOP,
    CMD_WRITE,
    CMD_READ,
    CMD_ACK
  } cmd_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_sample;
  } in_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_failed;
  } out_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_sample;
  } item_t;

  typedef struct packed {
    logic [15:0] phase_ticks;
    logic [7:0]  ack_timeout;
  } cfg_t;

endpackage

@@ sv/i2cbm_front.sv @@
module i2cbm_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  i2cbm_pkg::in_t    in_data,
  output logic              push,
  output i2cbm_pkg::item_t  push_item,
  input  logic              queue_full
);
  import i2cbm_pkg::*;

  cmd_t cmd;
  logic unused_clk_rst;

  always_comb begin
    case (in_data.req_type)
      REQ_START: cmd = CMD_START;
      REQ_STOP:  cmd = CMD_STOP;
      REQ_WRITE: cmd = CMD_WRITE;
      REQ_READ:  cmd = CMD_READ;
      REQ_ACK:   cmd = CMD_ACK;
      default:   cmd = CMD_TICK;
    endcase
  end

  assign unused_clk_rst = clk & rst;
  assign in_ready = !queue_full;
  assign push = in_valid && !queue_full;
  assign push_item = '{cmd: cmd, tx_byte: in_data.tx_byte, send_ack: in_data.send_ack,
                       sda_sample: in_data.sda_sample};

endmodule

@@ sv/i2cbm_queue.sv @@
module i2cbm_queue #(
  parameter int DEPTH = i2cbm_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  i2cbm_pkg::item_t  push_item,
  output logic              full,
  input  logic              pop,
  output logic              pop_valid,
  output i2cbm_pkg::item_t  pop_item
);
  import i2cbm_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t            mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_item  = mem[rd_ptr];
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (!push && do_pop) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

@@ sv/i2cbm_back.sv @@
module i2cbm_back (
  input  logic              clk,
  input  logic              rst,
  input  i2cbm_pkg::cfg_t   cfg,
  input  logic              q_valid,
  input  i2cbm_pkg::item_t  q_item,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output i2cbm_pkg::out_t   out_data
);
  import i2cbm_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_END,
    S_BEG0, S_BEG1, S_BEG2,
    S_FIN0, S_FIN1, S_FIN2,
    S_WFIRST, S_WHIGH, S_WLOW,
    S_RHIGH, S_RSAMP,
    S_ANS0, S_ANS1, S_ANS2, S_ANS3,
    S_K0, S_K1, S_KPOLL,
    S_TO1, S_TO2, S_KLOW
  } step_t;

  step_t       step, step_next;
  logic [3:0]  bit_count, bit_count_next;
  logic [7:0]  shift_reg, shift_reg_next;
  logic [15:0] phase_count, phase_count_next;
  logic [7:0]  poll_count, poll_count_next;
  logic        scl_reg, scl_reg_next;
  logic        sda_reg, sda_reg_next;
  logic        nack_flag, nack_flag_next;
  logic        send_ack_reg, send_ack_reg_next;
  logic [7:0]  rx_hold, rx_hold_next;
  logic        done_next;
  logic        take;

  assign take  = q_valid && (!out_valid || out_ready);
  assign q_pop = take;

  always_comb begin
    logic [15:0] plen;
    logic [15:0] wait_len;
    step_t       nxt;
    step_next         = step;
    bit_count_next    = bit_count;
    shift_reg_next    = shift_reg;
    phase_count_next  = phase_count;
    poll_count_next   = poll_count;
    scl_reg_next      = scl_reg;
    sda_reg_next      = sda_reg;
    nack_flag_next    = nack_flag;
    send_ack_reg_next = send_ack_reg;
    rx_hold_next      = rx_hold;
    done_next         = 1'b0;
    plen     = (cfg.phase_ticks == 16'd0) ? 16'd1 : cfg.phase_ticks;
    wait_len = plen;
    nxt      = S_END;

    if (step == S_IDLE && q_item.cmd != CMD_TICK) begin
      phase_count_next = '0;
      bit_count_next   = '0;
      case (q_item.cmd)
        CMD_START: step_next = S_BEG0;
        CMD_STOP:  step_next = S_FIN0;
        CMD_WRITE: begin
          step_next      = S_WFIRST;
          shift_reg_next = q_item.tx_byte;
        end
        CMD_READ: begin
          step_next         = S_RHIGH;
          shift_reg_next    = '0;
          send_ack_reg_next = q_item.send_ack;
        end
        default: begin
          step_next       = S_K0;
          poll_count_next = '0;
          nack_flag_next  = 1'b0;
        end
      endcase
    end

    if (step_next != S_IDLE) begin
      if (phase_count_next == 16'd0) begin
        case (step_next)
          S_BEG0: begin sda_reg_next = 1'b1; scl_reg_next = 1'b1; nxt = S_BEG1; end
          S_BEG1: begin sda_reg_next = 1'b0; nxt = S_BEG2; end
          S_BEG2: begin scl_reg_next = 1'b0; nxt = S_END; end
          S_FIN0: begin sda_reg_next = 1'b0; nxt = S_FIN1; end
          S_FIN1: begin scl_reg_next = 1'b1; nxt = S_FIN2; end
          S_FIN2: begin sda_reg_next = 1'b1; nxt = S_END; end
          S_WFIRST: begin
            sda_reg_next = shift_reg_next[7];
            nxt = S_WHIGH;
          end
          S_WHIGH: begin scl_reg_next = 1'b1; nxt = S_WLOW; end
          S_WLOW: begin
            scl_reg_next   = 1'b0;
            shift_reg_next = {shift_reg_next[6:0], 1'b0};
            bit_count_next = bit_count_next + 4'd1;
            if (bit_count_next < 4'd8) begin
              sda_reg_next = shift_reg_next[7];
              nxt = S_WHIGH;
            end else begin
              sda_reg_next = 1'b1;
              nxt = S_END;
              wait_len = '0;
            end
          end
          S_RHIGH: begin scl_reg_next = 1'b1; nxt = S_RSAMP; end
          S_RSAMP: begin
            shift_reg_next = {shift_reg_next[6:0], q_item.sda_sample};
            scl_reg_next   = 1'b0;
            bit_count_next = bit_count_next + 4'd1;
            if (bit_count_next < 4'd8) begin
              nxt = S_RHIGH;
            end else begin
              rx_hold_next = shift_reg_next;
              nxt = S_ANS0;
            end
          end
          S_ANS0: begin sda_reg_next = !send_ack_reg_next; nxt = S_ANS1; end
          S_ANS1: begin scl_reg_next = 1'b1; nxt = S_ANS2; end
          S_ANS2: begin
            scl_reg_next = 1'b0;
            nxt = send_ack_reg_next ? S_ANS3 : S_END;
          end
          S_ANS3: begin sda_reg_next = 1'b1; nxt = S_END; end
          S_K0: begin sda_reg_next = 1'b1; nxt = S_K1; end
          S_K1: begin scl_reg_next = 1'b1; nxt = S_KPOLL; end
          S_KPOLL: begin
            if (!q_item.sda_sample) begin
              scl_reg_next = 1'b0;
              nxt = S_END;
            end else if (poll_count_next >= cfg.ack_timeout) begin
              nack_flag_next = 1'b1;
              sda_reg_next   = 1'b0;
              nxt = S_TO1;
            end else begin
              poll_count_next = poll_count_next + 8'd1;
              nxt = S_KPOLL;
              wait_len = '0;
            end
          end
          S_TO1:  begin scl_reg_next = 1'b1; nxt = S_TO2; end
          S_TO2:  begin sda_reg_next = 1'b1; nxt = S_KLOW; end
          S_KLOW: begin scl_reg_next = 1'b0; nxt = S_END; end
          default: begin nxt = S_END; wait_len = '0; end
        endcase
        step_next        = nxt;
        phase_count_next = wait_len;
      end
      if (phase_count_next != 16'd0) begin
        phase_count_next = phase_count_next - 16'd1;
      end
      if (phase_count_next == 16'd0 && step_next == S_END) begin
        done_next = 1'b1;
        step_next = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step         <= S_IDLE;
      bit_count    <= '0;
      shift_reg    <= '0;
      phase_count  <= '0;
      poll_count   <= '0;
      scl_reg      <= 1'b1;
      sda_reg      <= 1'b1;
      nack_flag    <= 1'b0;
      send_ack_reg <= 1'b0;
      rx_hold      <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (take) begin
        step         <= step_next;
        bit_count    <= bit_count_next;
        shift_reg    <= shift_reg_next;
        phase_count  <= phase_count_next;
        poll_count   <= poll_count_next;
        scl_reg      <= scl_reg_next;
        sda_reg      <= sda_reg_next;
        nack_flag    <= nack_flag_next;
        send_ack_reg <= send_ack_reg_next;
        rx_hold      <= rx_hold_next;
        out_valid    <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data <= '{scl_level: scl_reg_next, sda_level: sda_reg_next,
                    busy_res: (step_next != S_IDLE), done_res: done_next,
                    rx_byte: rx_hold_next, ack_failed: nack_flag_next};
    end
  end

endmodule

@@ sv/i2c_bit_level_master_core.sv @@
// I2C bit-level master. Each input transfer is one bus tick carrying the
// sampled SDA level and optionally a command (start, stop, write byte,
// read byte with ACK/NACK, wait for ACK); each output transfer gives the
// SCL/SDA drive levels, busy, done, the last received byte and the ACK
// failure flag for that tick. One tick is taken per clock while the queue
// is not full: the front end decodes the command into a small queue, and
// the sequencer consumes one queue entry per clock, unless the output is
// stalled, into a registered output. Commands arriving while a sequence
// is running are ignored. Bus phases last phase_ticks ticks
// (register 0, zero counts as one); ack_timeout (register 1) bounds the
// number of high SDA polls before a wait-for-ACK fails and issues a stop.
// Write configuration only while idle.
module i2c_bit_level_master_core #(
  parameter int QUEUE_DEPTH = i2cbm_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  i2cbm_pkg::in_t    in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output i2cbm_pkg::out_t   out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import i2cbm_pkg::*;

  cfg_t  cfg;
  logic  push;
  item_t push_item;
  logic  queue_full;
  logic  pop;
  logic  pop_valid;
  item_t pop_item;
  logic  cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.phase_ticks <= PHASE_TICKS_RESET;
      cfg.ack_timeout <= ACK_TIMEOUT_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_PHASE_TICKS: cfg.phase_ticks <= pwdata[15:0];
        REG_ACK_TIMEOUT: cfg.ack_timeout <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_PHASE_TICKS: prdata = {16'd0, cfg.phase_ticks};
      REG_ACK_TIMEOUT: prdata = {24'd0, cfg.ack_timeout};
      default:         prdata = '0;
    endcase
  end

  i2cbm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push       (push),
    .push_item  (push_item),
    .queue_full (queue_full)
  );

  i2cbm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .pop_valid (pop_valid),
    .pop_item  (pop_item)
  );

  i2cbm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (pop_valid),
    .q_item    (pop_item),
    .q_pop     (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ dv/i2cbm_line_checker.sv @@
module i2cbm_line_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  i2cbm_pkg::in_t    in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  i2cbm_pkg::out_t   out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  output int                fail_count,
  output int                pending,
  output logic              engine_busy,
  output int                n_checked,
  output int                n_done,
  output int                n_timeouts
);
  timeunit 1ns;
  timeprecision 1ps;
  import i2cbm_pkg::*;

  localparam logic [2:0] ADDR_PHASE   = {REG_PHASE_TICKS, 2'b00};
  localparam logic [2:0] ADDR_TIMEOUT = {REG_ACK_TIMEOUT, 2'b00};

  typedef enum logic [4:0] {
    SEQ_IDLE, SEQ_END,
    BEG_REL, BEG_SDA, BEG_SCL,
    FIN_SDA, FIN_SCL, FIN_REL,
    WR_FIRST, WR_HIGH, WR_LOW,
    RD_HIGH, RD_SAMPLE,
    ANS_SDA, ANS_HIGH, ANS_LOW, ANS_REL,
    KW_REL, KW_HIGH, KW_POLL,
    TO_SCL, TO_SDA, TO_LOW
  } step_t;

  step_t       step = SEQ_IDLE;
  logic [3:0]  bits = '0;
  logic [7:0]  shreg = '0;
  logic [15:0] phase_left = '0;
  logic [7:0]  polls = '0;
  logic        scl_q = 1'b1;
  logic        sda_q = 1'b1;
  logic        fail_q = 1'b0;
  logic        ack_q = 1'b0;
  logic [7:0]  rx_q = '0;
  logic [15:0] phase_cfg = PHASE_TICKS_RESET;
  logic [7:0]  timeout_cfg = ACK_TIMEOUT_RESET;

  out_t exp_lines[$];
  int   n_bad = 0;

  assign fail_count  = n_bad;
  assign engine_busy = (step != SEQ_IDLE);

  // one group of line changes at the start of a phase
  function automatic void line_group(logic sda_in);
    logic [15:0] plen;
    logic [15:0] hold;
    step_t       nxt;
    plen = (phase_cfg == '0) ? 16'd1 : phase_cfg;
    hold = plen;
    nxt  = SEQ_END;
    case (step)
      BEG_REL: begin sda_q = 1'b1; scl_q = 1'b1; nxt = BEG_SDA; end
      BEG_SDA: begin sda_q = 1'b0; nxt = BEG_SCL; end
      BEG_SCL: scl_q = 1'b0;
      FIN_SDA: begin sda_q = 1'b0; nxt = FIN_SCL; end
      FIN_SCL: begin scl_q = 1'b1; nxt = FIN_REL; end
      FIN_REL: sda_q = 1'b1;
      WR_FIRST: begin sda_q = shreg[7]; nxt = WR_HIGH; end
      WR_HIGH: begin scl_q = 1'b1; nxt = WR_LOW; end
      WR_LOW: begin
        scl_q = 1'b0;
        shreg = shreg << 1;
        bits  = bits + 4'd1;
        if (bits < 4'd8) begin
          sda_q = shreg[7];
          nxt   = WR_HIGH;
        end else begin
          sda_q = 1'b1;
          hold  = '0;
        end
      end
      RD_HIGH: begin scl_q = 1'b1; nxt = RD_SAMPLE; end
      RD_SAMPLE: begin
        shreg = {shreg[6:0], sda_in};
        scl_q = 1'b0;
        bits  = bits + 4'd1;
        if (bits < 4'd8) begin
          nxt = RD_HIGH;
        end else begin
          rx_q = shreg;
          nxt  = ANS_SDA;
        end
      end
      ANS_SDA: begin sda_q = !ack_q; nxt = ANS_HIGH; end
      ANS_HIGH: begin scl_q = 1'b1; nxt = ANS_LOW; end
      ANS_LOW: begin scl_q = 1'b0; nxt = ack_q ? ANS_REL : SEQ_END; end
      ANS_REL: sda_q = 1'b1;
      KW_REL: begin sda_q = 1'b1; nxt = KW_HIGH; end
      KW_HIGH: begin scl_q = 1'b1; nxt = KW_POLL; end
      KW_POLL: begin
        if (!sda_in) begin
          scl_q = 1'b0;
        end else if (polls >= timeout_cfg) begin
          fail_q = 1'b1;
          sda_q  = 1'b0;
          nxt    = TO_SCL;
          n_timeouts++;
        end else begin
          polls = polls + 8'd1;
          nxt   = KW_POLL;
          hold  = '0;
        end
      end
      TO_SCL: begin scl_q = 1'b1; nxt = TO_SDA; end
      TO_SDA: begin sda_q = 1'b1; nxt = TO_LOW; end
      TO_LOW: scl_q = 1'b0;
      default: hold = '0;
    endcase
    step       = nxt;
    phase_left = hold;
  endfunction

  function automatic out_t bus_tick(in_t t);
    out_t r;
    logic fin;
    fin = 1'b0;
    if (step == SEQ_IDLE) begin
      case (t.req_type)
        REQ_START: step = BEG_REL;
        REQ_STOP:  step = FIN_SDA;
        REQ_WRITE: begin step = WR_FIRST; shreg = t.tx_byte; end
        REQ_READ:  begin step = RD_HIGH; shreg = '0; ack_q = t.send_ack; end
        REQ_ACK:   begin step = KW_REL; polls = '0; fail_q = 1'b0; end
        default: ;
      endcase
      if (step != SEQ_IDLE) begin
        phase_left = '0;
        bits       = '0;
      end
    end
    if (step != SEQ_IDLE) begin
      if (phase_left == '0) line_group(t.sda_sample);
      if (phase_left != '0) phase_left = phase_left - 16'd1;
      if (phase_left == '0 && step == SEQ_END) begin
        fin  = 1'b1;
        step = SEQ_IDLE;
      end
    end
    r.scl_level  = scl_q;
    r.sda_level  = sda_q;
    r.busy_res   = (step != SEQ_IDLE);
    r.done_res   = fin;
    r.rx_byte    = rx_q;
    r.ack_failed = fail_q;
    return r;
  endfunction

  always @(posedge clk) begin
    out_t want;
    out_t seen;
    logic bad;
    if (rst) begin
      step        = SEQ_IDLE;
      bits        = '0;
      shreg       = '0;
      phase_left  = '0;
      polls       = '0;
      scl_q       = 1'b1;
      sda_q       = 1'b1;
      fail_q      = 1'b0;
      ack_q       = 1'b0;
      rx_q        = '0;
      phase_cfg   = PHASE_TICKS_RESET;
      timeout_cfg = ACK_TIMEOUT_RESET;
      exp_lines.delete();
    end else begin
      if (out_valid && out_ready) begin
        seen = out_data;
        if (exp_lines.size() == 0) begin
          if (n_bad < 10)
            $display("[%0t] unexpected result: scl %b sda %b busy %b done %b rx %h nack %b",
                     $time, seen.scl_level, seen.sda_level, seen.busy_res, seen.done_res,
                     seen.rx_byte, seen.ack_failed);
          n_bad++;
        end else begin
          want = exp_lines.pop_front();
          bad  = (seen.scl_level !== want.scl_level) || (seen.sda_level !== want.sda_level) ||
                 (seen.busy_res !== want.busy_res) || (seen.done_res !== want.done_res) ||
                 (seen.rx_byte !== want.rx_byte) || (seen.ack_failed !== want.ack_failed);
          if (bad) begin
            if (n_bad < 10)
              $display({"[%0t] result mismatch: exp scl %b sda %b busy %b done %b rx %h nack %b",
                        " / got scl %b sda %b busy %b done %b rx %h nack %b"}, $time,
                       want.scl_level, want.sda_level, want.busy_res, want.done_res,
                       want.rx_byte, want.ack_failed, seen.scl_level, seen.sda_level,
                       seen.busy_res, seen.done_res, seen.rx_byte, seen.ack_failed);
            n_bad++;
          end
          n_checked++;
          if (want.done_res) n_done++;
        end
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr == ADDR_PHASE) phase_cfg = pwdata[15:0];
        else if (paddr == ADDR_TIMEOUT) timeout_cfg = pwdata[7:0];
      end
      if (in_valid && in_ready) exp_lines.push_back(bus_tick(in_data));
    end
    pending = exp_lines.size();
  end

endmodule

@@ dv/i2c_bit_level_master_core_tb.sv @@
module i2c_bit_level_master_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import i2cbm_pkg::*;

  localparam logic [2:0] REQ_SPARE_A  = 3'd6;
  localparam logic [2:0] REQ_SPARE_B  = 3'd7;
  localparam logic [2:0] ADDR_PHASE   = {REG_PHASE_TICKS, 2'b00};
  localparam logic [2:0] ADDR_TIMEOUT = {REG_ACK_TIMEOUT, 2'b00};
  localparam int SDA_RANDOM  = 0;
  localparam int SDA_LOW     = 1;
  localparam int SDA_HIGH    = 2;
  localparam int CYCLE_LIMIT = 4_000_000;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int   fail_count;
  int   pending;
  logic engine_busy;
  int   n_checked;
  int   n_done;
  int   n_timeouts;

  int n_sent = 0;
  int burst_left = 0;
  int cur_phase = PHASE_TICKS_RESET;
  int cur_timeout = ACK_TIMEOUT_RESET;
  bit fast = 1'b0;
  bit noisy = 1'b0;
  int stall_left = 0;
  int stall_mode = 0;

  i2c_bit_level_master_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  i2cbm_line_checker lines_chk (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .fail_count  (fail_count),
    .pending     (pending),
    .engine_busy (engine_busy),
    .n_checked   (n_checked),
    .n_done      (n_done),
    .n_timeouts  (n_timeouts)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    for (int c = 0; c < CYCLE_LIMIT; c++) @(posedge clk);
    $display("i2c_bit_level_master_core_tb: done, errors");
    $finish;
  end

  // receiver back-pressure, drawn from four modes that change at random
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(16, 300);
    end else begin
      stall_left = stall_left - 1;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= ((stall_left % 7) < 3);
    endcase
  end

  function automatic in_t make_item(logic [2:0] req, logic sda);
    in_t it;
    it.req_type   = req;
    it.tx_byte    = 8'($urandom_range(0, 255));
    it.send_ack   = 1'($urandom_range(0, 1));
    it.sda_sample = sda;
    return it;
  endfunction

  function automatic logic [2:0] filler_req();
    int r;
    r = $urandom_range(0, 19);
    if (r < 2) return REQ_SPARE_A;
    if (r < 4) return REQ_SPARE_B;
    if (noisy && r < 7) return 3'($urandom_range(1, 5));
    return REQ_TICK;
  endfunction

  task automatic send_item(input in_t it);
    int gap;
    int r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      r = $urandom_range(0, 9);
      if (r < 4) gap = 0;
      else if (r < 9) gap = $urandom_range(1, 3);
      else gap = $urandom_range(4, 15);
      if (fast) gap = 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic settle(input int chunk);
    drain_results();
    while (engine_busy) begin
      repeat (chunk) send_item(make_item(REQ_TICK, 1'($urandom_range(0, 1))));
      drain_results();
    end
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic reconfigure(input int phase_val, input int timeout_val);
    settle(16);
    reg_write(ADDR_PHASE, 32'(phase_val));
    reg_write(ADDR_TIMEOUT, 32'(timeout_val));
    cur_phase   = phase_val;
    cur_timeout = timeout_val;
  endtask

  // command transfer followed by enough ticks to finish it, adjusted by a slack that may be negative
  task automatic run_command(input logic [2:0] cmd, input logic [7:0] tx, input logic ack_bit,
                             input int sda_mode, input int highs, input bit to_case,
                             input int slack);
    int   plen;
    int   span;
    int   poll0;
    int   nhigh;
    in_t  it;
    logic sda;
    plen  = (cur_phase == 0) ? 1 : cur_phase;
    poll0 = 2 * plen;
    nhigh = to_case ? cur_timeout + 1 : highs;
    case (cmd)
      REQ_WRITE: span = 16 * plen + 1;
      REQ_READ:  span = 20 * plen;
      REQ_ACK:   span = poll0 + nhigh + (to_case ? 4 * plen : plen);
      default:   span = 3 * plen;
    endcase
    span = span + slack;
    if (span < 1) span = 1;
    for (int k = 0; k < span; k++) begin
      case (sda_mode)
        SDA_LOW:  sda = 1'b0;
        SDA_HIGH: sda = 1'b1;
        default:  sda = 1'($urandom_range(0, 1));
      endcase
      if (cmd == REQ_ACK && k >= poll0) begin
        if (k < poll0 + nhigh) sda = 1'b1;
        else if (k == poll0 + nhigh && !to_case) sda = 1'b0;
      end
      it = make_item((k == 0) ? cmd : filler_req(), sda);
      if (k == 0) begin
        it.tx_byte  = tx;
        it.send_ack = ack_bit;
      end
      send_item(it);
    end
  endtask

  task automatic random_phase(input int quota);
    int         base;
    int         slack;
    int         cap;
    int         sda_mode;
    logic [2:0] cmd;
    bit         to_case;
    base  = n_sent;
    noisy = 1'b1;
    while (n_sent - base < quota) begin
      if ($urandom_range(0, 99) < 85) begin
        cmd      = 3'($urandom_range(1, 5));
        slack    = ($urandom_range(0, 4) == 0) ? -int'($urandom_range(1, 5))
                                               : int'($urandom_range(0, 4));
        cap      = (cur_timeout < 12) ? cur_timeout : 12;
        to_case  = (cur_timeout <= 30) ? ($urandom_range(0, 2) == 0)
                                       : ($urandom_range(0, 19) == 0);
        sda_mode = ($urandom_range(0, 5) == 0) ? SDA_HIGH : SDA_RANDOM;
        run_command(cmd, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), sda_mode,
                    $urandom_range(0, cap), to_case, slack);
      end else begin
        repeat ($urandom_range(1, 6))
          send_item(make_item(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1))));
      end
    end
    noisy = 1'b0;
  endtask

  initial begin
    int total_bad;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, reset configuration
    send_item(make_item(REQ_TICK, 1'b1));
    send_item(make_item(REQ_SPARE_A, 1'b0));
    send_item(make_item(REQ_SPARE_B, 1'b1));
    run_command(REQ_START, 8'h00, 1'b0, SDA_RANDOM, 0, 1'b0, 0);
    run_command(REQ_WRITE, 8'hFF, 1'b0, SDA_RANDOM, 0, 1'b0, 0);
    run_command(REQ_WRITE, 8'h00, 1'b1, SDA_RANDOM, 0, 1'b0, 0);
    run_command(REQ_WRITE, 8'hA5, 1'b0, SDA_HIGH, 0, 1'b0, 0);
    run_command(REQ_ACK, 8'h00, 1'b0, SDA_RANDOM, 0, 1'b0, 0);
    run_command(REQ_ACK, 8'hFF, 1'b1, SDA_RANDOM, 3, 1'b0, 0);
    run_command(REQ_READ, 8'h00, 1'b1, SDA_HIGH, 0, 1'b0, 0);
    run_command(REQ_READ, 8'hFF, 1'b0, SDA_LOW, 0, 1'b0, 0);
    run_command(REQ_READ, 8'h5A, 1'b1, SDA_RANDOM, 0, 1'b0, 1);
    // start lands while the write is still running
    run_command(REQ_WRITE, 8'h3C, 1'b1, SDA_RANDOM, 0, 1'b0, -6);
    run_command(REQ_START, 8'h00, 1'b0, SDA_RANDOM, 0, 1'b0, 2);
    run_command(REQ_ACK, 8'h00, 1'b0, SDA_RANDOM, 0, 1'b1, 0);
    run_command(REQ_STOP, 8'h00, 1'b0, SDA_RANDOM, 0, 1'b0, 0);

    random_phase(90);
    reconfigure(1, 1);
    random_phase(90);
    reconfigure(0, 0);
    random_phase(70);
    reconfigure(3, 255);
    random_phase(70);
    reconfigure($urandom_range(4, 7), $urandom_range(2, 30));
    random_phase(70);

    // long phase: one start condition run to completion
    reconfigure(16'h0081, 7);
    fast = 1'b1;
    run_command(REQ_START, 8'h00, 1'b0, SDA_RANDOM, 0, 1'b0, 0);
    settle(1024);
    fast = 1'b0;
    reconfigure(1, 3);
    random_phase(40);

    drain_results();
    repeat (8) @(posedge clk);
    total_bad = fail_count + pending;
    $display("run: %0d tick transfers in, %0d results checked, %0d commands finished, %0d ack timeouts",
             n_sent, n_checked, n_done, n_timeouts);
    $display("run: phase lengths 0 to 129, ack limits 0 to 255, stalls and gaps on both sides");
    if (total_bad == 0) begin
      $display("i2c_bit_level_master_core_tb: done, clean");
    end else begin
      $display("i2c_bit_level_master_core_tb: done, errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/i2cbm_pkg.sv
sv/i2cbm_front.sv
sv/i2cbm_queue.sv
sv/i2cbm_back.sv
sv/i2c_bit_level_master_core.sv
dv/i2cbm_line_checker.sv
dv/i2c_bit_level_master_core_tb.sv
